// ===== src/ecx_pkg.sv =====
// ----------------------------------------------------------------------------
// ecx_pkg: shared definitions for the signature list certificate extractor
// Holds the parser phase codes, the list and entry caps, the X.509 type GUID
// and the certificate byte record that travels from the parser to the output.
// ----------------------------------------------------------------------------
`default_nettype none

package ecx_pkg;

   localparam int HDR_BYTES   = 28;
   localparam int GUID_BYTES  = 16;
   localparam int MAX_LISTS   = 256;
   localparam int MAX_ENTRIES = 4096;

   localparam int LIST_CNT_W  = $clog2(MAX_LISTS + 1);
   localparam int ENTRY_CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int CERT_NUM_W  = 20;

   localparam logic [7:0] X509_GUID [GUID_BYTES] = '{
      8'hA1, 8'h59, 8'hC0, 8'hA5, 8'hE4, 8'h94, 8'hA7, 8'h4A,
      8'h87, 8'hB5, 8'hAB, 8'h15, 8'h5C, 8'h2B, 8'hF0, 8'h72
   };

   typedef enum logic [4:0] {
      PH_HEADER     = 5'b00001,
      PH_SKIP_EXTRA = 5'b00010,
      PH_ENTRY      = 5'b00100,
      PH_SKIP_LIST  = 5'b01000,
      PH_STOPPED    = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [7:0]            cert_byte;
      logic                  cert_first;
      logic                  cert_last;
      logic [CERT_NUM_W-1:0] cert_number;
   } cert_result_type;

endpackage

`default_nettype wire

// ===== src/ecx_parser.sv =====
// ----------------------------------------------------------------------------
// ecx_parser: per-byte signature list parser
// Holds the parser state and decides, for each accepted byte, the byte's
// role in the buffer and whether it is a certificate byte to pass on.
// ----------------------------------------------------------------------------
`default_nettype none

module ecx_parser
   import ecx_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step,
   input  wire logic [7:0]      data_byte,
   input  wire logic            end_of_buffer,
   input  wire logic [31:0]     buffer_length,
   output logic                 emit,
   output cert_result_type      result
);

   phase_type               phase_ff, phase_in;
   logic [4:0]              hbc_ff, hbc_in;
   logic [31:0]             list_len_ff, list_len_in;
   logic [31:0]             extra_ff, extra_in;
   logic [31:0]             entry_len_ff, entry_len_in;
   logic                    guid_ok_ff, guid_ok_in;
   logic [31:0]             offset_ff, offset_in;
   logic [31:0]             list_start_ff, list_start_in;
   logic [32:0]             list_end_ff, list_end_in;
   logic [32:0]             entry_start_ff, entry_start_in;
   logic [31:0]             ebc_ff, ebc_in;
   logic [ENTRY_CNT_W-1:0]  entries_ff, entries_in;
   logic [LIST_CNT_W-1:0]   lists_ff, lists_in;
   logic [CERT_NUM_W-1:0]   certs_ff, certs_in;

   logic [32:0]             here;
   logic                    reach_entries;
   logic                    entry_fits;
   logic                    reach_end;
   logic                    room_for_header;

   phase_type               ph;
   logic [31:0]             ebc_s;
   logic [4:0]              hbc_s;
   logic [LIST_CNT_W-1:0]   lists_s;

   logic [31:0]             entry_len_full;
   logic [32:0]             list_end_new;
   logic [33:0]             entry_start_new;
   logic                    header_bad;
   logic                    entry_last;

   assign here            = {1'b0, offset_ff};
   assign reach_entries   = here >= entry_start_ff;
   assign entry_fits      = (entries_ff < ENTRY_CNT_W'(MAX_ENTRIES)) &&
                            (here + {1'b0, entry_len_ff} <= list_end_ff);
   assign reach_end       = here >= list_end_ff;
   assign room_for_header = here + 33'(HDR_BYTES) <= {1'b0, buffer_length};

   // Settle the phase for the byte now arriving.
   always_comb begin
      ph      = phase_ff;
      ebc_s   = ebc_ff;
      hbc_s   = hbc_ff;
      lists_s = lists_ff;
      if (ph == PH_SKIP_EXTRA && reach_entries) begin
         ph    = PH_ENTRY;
         ebc_s = '0;
      end
      if (ph == PH_ENTRY && ebc_s == '0 && !entry_fits) begin
         ph = PH_SKIP_LIST;
      end
      if (ph == PH_SKIP_LIST && reach_end) begin
         ph      = PH_HEADER;
         hbc_s   = '0;
         lists_s = lists_s + LIST_CNT_W'(1);
      end
      if (ph == PH_HEADER && hbc_s == '0 &&
          !(lists_s < LIST_CNT_W'(MAX_LISTS) && room_for_header)) begin
         ph = PH_STOPPED;
      end
   end

   assign entry_len_full  = {data_byte, entry_len_ff[23:0]};
   assign list_end_new    = {1'b0, list_start_ff} + {1'b0, list_len_ff};
   assign entry_start_new = {2'b00, list_start_ff} + {2'b00, extra_ff} + 34'(HDR_BYTES);
   assign header_bad      = ({1'b0, list_len_ff} < {1'b0, extra_ff} + 33'(HDR_BYTES)) ||
                            (list_end_new > {1'b0, buffer_length}) ||
                            (entry_len_full <= 32'(GUID_BYTES)) ||
                            (entry_len_full > list_len_ff);
   assign entry_last      = (ebc_s + 32'd1) == entry_len_ff;

   always_comb begin
      phase_in       = ph;
      hbc_in         = hbc_s;
      list_len_in    = list_len_ff;
      extra_in       = extra_ff;
      entry_len_in   = entry_len_ff;
      guid_ok_in     = guid_ok_ff;
      list_start_in  = list_start_ff;
      list_end_in    = list_end_ff;
      entry_start_in = entry_start_ff;
      ebc_in         = ebc_s;
      entries_in     = entries_ff;
      lists_in       = lists_s;
      certs_in       = certs_ff;
      emit           = 1'b0;
      result         = '{cert_byte: data_byte, cert_first: ebc_s == 32'(GUID_BYTES),
                         cert_last: entry_last, cert_number: certs_ff};

      unique case (ph)
         PH_HEADER: begin
            if (hbc_s == '0) begin
               list_len_in   = '0;
               extra_in      = '0;
               entry_len_in  = '0;
               list_start_in = offset_ff;
            end
            if (hbc_s < 5'(GUID_BYTES)) begin
               guid_ok_in = ((hbc_s == '0) ? 1'b1 : guid_ok_ff) &&
                            (data_byte == X509_GUID[hbc_s[3:0]]);
            end else if (hbc_s < 5'd20) begin
               list_len_in[8*hbc_s[1:0] +: 8] = data_byte;
            end else if (hbc_s < 5'd24) begin
               extra_in[8*hbc_s[1:0] +: 8] = data_byte;
            end else begin
               entry_len_in[8*hbc_s[1:0] +: 8] = data_byte;
            end
            hbc_in = hbc_s + 5'd1;
            if (hbc_s == 5'(HDR_BYTES - 1)) begin
               hbc_in = '0;
               if (header_bad) begin
                  phase_in = PH_STOPPED;
               end else begin
                  list_end_in    = list_end_new;
                  entry_start_in = entry_start_new[32:0];
                  entries_in     = '0;
                  ebc_in         = '0;
                  phase_in       = guid_ok_ff ? PH_SKIP_EXTRA : PH_SKIP_LIST;
               end
            end
         end
         PH_ENTRY: begin
            emit = ebc_s >= 32'(GUID_BYTES);
            if (entry_last) begin
               ebc_in     = '0;
               entries_in = entries_ff + ENTRY_CNT_W'(1);
               certs_in   = certs_ff + CERT_NUM_W'(1);
            end else begin
               ebc_in = ebc_s + 32'd1;
            end
         end
         PH_SKIP_EXTRA, PH_SKIP_LIST, PH_STOPPED: begin
         end
         default: begin
         end
      endcase

      offset_in = (offset_ff == 32'hFFFF_FFFF) ? offset_ff : offset_ff + 32'd1;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && end_of_buffer)) begin
         phase_ff       <= PH_HEADER;
         hbc_ff         <= '0;
         list_len_ff    <= '0;
         extra_ff       <= '0;
         entry_len_ff   <= '0;
         guid_ok_ff     <= 1'b1;
         offset_ff      <= '0;
         list_end_ff    <= '0;
         entry_start_ff <= '0;
         ebc_ff         <= '0;
         entries_ff     <= '0;
         lists_ff       <= '0;
         certs_ff       <= '0;
      end else if (step) begin
         phase_ff       <= phase_in;
         hbc_ff         <= hbc_in;
         list_len_ff    <= list_len_in;
         extra_ff       <= extra_in;
         entry_len_ff   <= entry_len_in;
         guid_ok_ff     <= guid_ok_in;
         offset_ff      <= offset_in;
         list_end_ff    <= list_end_in;
         entry_start_ff <= entry_start_in;
         ebc_ff         <= ebc_in;
         entries_ff     <= entries_in;
         lists_ff       <= lists_in;
         certs_ff       <= certs_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         list_start_ff <= list_start_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/ecx_out_queue.sv =====
// ----------------------------------------------------------------------------
// ecx_out_queue: two-entry result queue
// Holds certificate bytes until the consumer takes them, so the parser can
// take a new request while one result is still waiting.
// ----------------------------------------------------------------------------
`default_nettype none

module ecx_out_queue
   import ecx_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  cert_result_type       push_data,
   output logic                  full,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output cert_result_type       out_data
);

   cert_result_type ent_ff [2];
   logic            wr_ptr_ff, wr_ptr_in;
   logic            rd_ptr_ff, rd_ptr_in;
   logic [1:0]      count_ff, count_in;
   logic            pop;

   assign full      = count_ff == 2'd2;
   assign out_valid = count_ff != 2'd0;
   assign out_data  = ent_ff[rd_ptr_ff];
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== src/efi_signature_list_cert_extractor_core.sv =====
// ----------------------------------------------------------------------------
// efi_signature_list_cert_extractor_core: certificate extractor top level
// Parses a byte stream of UEFI signature lists and returns the bytes of each
// X.509 certificate, marked first and last, with its ordinal in the buffer.
//
//   Channel  Ports   Direction  Carries
//   request  req_*   in         one buffer byte and its end-of-buffer flag
//   response rsp_*   out        one certificate byte with marks and ordinal
//   config   csr_*   in         buffer length, written with csr_wr_en
//
// One request is taken per cycle; the parser state updates on the same edge.
// A certificate byte is registered in the result queue when its request is taken.
// Requests are refused only while both entries of the result queue are full.
// Synchronous reset clears the parser, the queue and the buffer length.
// ----------------------------------------------------------------------------
`default_nettype none

module efi_signature_list_cert_extractor_core
   import ecx_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [7:0]            req_data_byte,
   input  wire logic                  req_end_of_buffer,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [7:0]                 rsp_cert_byte,
   output logic                       rsp_cert_first,
   output logic                       rsp_cert_last,
   output logic [CERT_NUM_W-1:0]      rsp_cert_number,
   input  wire logic                  csr_wr_en,
   input  wire logic [31:0]           csr_wr_data
);

   logic [31:0]     buf_len_ff;
   logic            step;
   logic            emit;
   logic            queue_full;
   cert_result_type result;
   cert_result_type out_data;

   assign req_ready = !queue_full;
   assign step      = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_len_ff <= '0;
      end else if (csr_wr_en) begin
         buf_len_ff <= csr_wr_data;
      end
   end

   ecx_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .data_byte     (req_data_byte),
      .end_of_buffer (req_end_of_buffer),
      .buffer_length (buf_len_ff),
      .emit          (emit),
      .result        (result)
   );

   ecx_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (step && emit),
      .push_data (result),
      .full      (queue_full),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (out_data)
   );

   assign rsp_cert_byte   = out_data.cert_byte;
   assign rsp_cert_first  = out_data.cert_first;
   assign rsp_cert_last   = out_data.cert_last;
   assign rsp_cert_number = out_data.cert_number;

endmodule

`default_nettype wire
